// ----- hdl/timestamp_to_calendar_fields_macros.svh -----
// Assertion macros for the calendar conversion checker.
// Depends on nothing; included by the checker file.
`ifndef TIMESTAMP_TO_CALENDAR_FIELDS_MACROS_SVH
`define TIMESTAMP_TO_CALENDAR_FIELDS_MACROS_SVH
// Assert a property under the active-low reset.
`define TCF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that also holds during reset.
`define TCF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/tcf_pkg.sv -----
// Constants for the timestamp to calendar conversion.
// No dependencies.
package tcf_pkg;
  localparam int unsigned TsW = 49;
  localparam int unsigned DefMaxYear = 9999;
  localparam int unsigned YearW = 14;
  localparam logic [TsW-1:0] MsSec = 49'd1000;
  localparam logic [TsW-1:0] MsMin = 49'd60000;
  localparam logic [TsW-1:0] MsHour = 49'd3600000;
  localparam logic [TsW-1:0] MsDay = 49'd86400000;
  localparam logic [TsW-1:0] Ms28 = 49'd2419200000;
  localparam logic [TsW-1:0] Ms29 = 49'd2505600000;
  localparam logic [TsW-1:0] Ms30 = 49'd2592000000;
  localparam logic [TsW-1:0] Ms31 = 49'd2678400000;
  localparam logic [TsW-1:0] Ms365 = 49'd31536000000;
  localparam logic [TsW-1:0] Ms366 = 49'd31622400000;
  localparam logic [TsW-1:0] Ms4Y = 49'd126230400000;
  localparam logic [TsW-1:0] Ms100Y = 49'd3155673600000;
  localparam logic [TsW-1:0] Ms400Y = 49'd12622780800000;

  function automatic logic [4:0] mon_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2: d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction
endpackage

// ----- hdl/timestamp_to_calendar_fields.sv -----
// Timestamp to calendar fields on one shared compare/subtract unit; uses tcf_pkg.
// Each calendar or clock unit is one step that subtracts the unit from the
// remaining milliseconds while it fits, then leaves the step; steps run 400,
// 100 and 4 years, year, month, day, hour, minute and second.
// Not ready while busy: a new beat is taken only after the result is accepted.
// Reset: asynchronous, active low, clears the sequencer and all registers.
module timestamp_to_calendar_fields
  import tcf_pkg::*;
#(
  parameter int unsigned MAX_YEAR = DefMaxYear
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [TsW-1:0] timestamp_ms_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic valid_res_o,
  output logic [YearW-1:0] year_o,
  output logic [3:0] month_o,
  output logic [4:0] day_o,
  output logic [4:0] hour_o,
  output logic [5:0] minute_o,
  output logic [5:0] second_o,
  output logic [9:0] millisecond_o,
  output logic [2:0] weekday_o,
  output logic [8:0] day_of_year_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_C400, S_C100, S_C4, S_YEAR, S_MON, S_DAY, S_HOUR, S_MIN, S_SEC, S_OUT
  } state_e;

  localparam int unsigned YW = 20;

  state_e state_q;
  logic [TsW-1:0] rem_q;
  logic [YW-1:0] yr_q;
  logic [8:0] cyc_q;
  logic [3:0] mon_q;
  logic [4:0] day_q;
  logic [8:0] doy_q;
  logic [2:0] wd_q;
  logic [5:0] tq_q;
  logic [4:0] hour_q;
  logic [5:0] min_q, sec_q;
  logic [9:0] ms_q;
  logic out_q;

  logic [TsW-1:0] sub_b, sub_r;
  logic sub_ge;
  logic leap;
  logic [4:0] mlen;
  logic [TsW-1:0] mlen_ms;
  logic [2:0] mon_wd;
  logic ok;

  function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  // cyc_q is the year offset within the current 400-year cycle
  always_comb begin
    leap = (cyc_q[1:0] == 2'd3) && (cyc_q != 9'd99) && (cyc_q != 9'd199) &&
           (cyc_q != 9'd299);
    mlen = mon_len(mon_q, leap);
    mon_wd = mlen[2:0] - 3'd4;
    case (mlen)
      5'd28: mlen_ms = Ms28;
      5'd29: mlen_ms = Ms29;
      5'd30: mlen_ms = Ms30;
      default: mlen_ms = Ms31;
    endcase
  end

  // shared subtract/compare unit
  always_comb begin
    case (state_q)
      S_C400: sub_b = Ms400Y;
      S_C100: sub_b = Ms100Y;
      S_C4: sub_b = Ms4Y;
      S_YEAR: sub_b = leap ? Ms366 : Ms365;
      S_MON: sub_b = mlen_ms;
      S_DAY: sub_b = MsDay;
      S_HOUR: sub_b = MsHour;
      S_MIN: sub_b = MsMin;
      S_SEC: sub_b = MsSec;
      default: sub_b = '0;
    endcase
    sub_ge = rem_q >= sub_b;
    sub_r = rem_q - sub_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q <= '0;
      yr_q <= '0;
      cyc_q <= '0;
      mon_q <= '0;
      day_q <= '0;
      doy_q <= '0;
      wd_q <= '0;
      tq_q <= '0;
      hour_q <= '0;
      min_q <= '0;
      sec_q <= '0;
      ms_q <= '0;
      out_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rem_q <= timestamp_ms_i;
            yr_q <= YW'(1);
            cyc_q <= '0;
            wd_q <= 3'd1;
            state_q <= S_C400;
          end
        end
        S_C400: begin
          if (sub_ge) begin
            rem_q <= sub_r;
            yr_q <= yr_q + YW'(400);
          end else state_q <= S_C100;
        end
        S_C100: begin
          // stop after three centuries: the last day of the cycle stays here
          if (sub_ge && cyc_q != 9'd300) begin
            rem_q <= sub_r;
            yr_q <= yr_q + YW'(100);
            cyc_q <= cyc_q + 9'd100;
            wd_q <= wd_add(wd_q, 3'd5);
          end else state_q <= S_C4;
        end
        S_C4: begin
          if (sub_ge) begin
            rem_q <= sub_r;
            yr_q <= yr_q + YW'(4);
            cyc_q <= cyc_q + 9'd4;
            wd_q <= wd_add(wd_q, 3'd5);
          end else state_q <= S_YEAR;
        end
        S_YEAR: begin
          if (sub_ge) begin
            rem_q <= sub_r;
            yr_q <= yr_q + YW'(1);
            cyc_q <= cyc_q + 9'd1;
            wd_q <= wd_add(wd_q, leap ? 3'd2 : 3'd1);
          end else begin
            doy_q <= 9'd1;
            mon_q <= 4'd1;
            state_q <= S_MON;
          end
        end
        S_MON: begin
          if (sub_ge && mon_q != 4'd12) begin
            rem_q <= sub_r;
            mon_q <= mon_q + 4'd1;
            doy_q <= doy_q + {4'd0, mlen};
            wd_q <= wd_add(wd_q, mon_wd);
          end else begin
            day_q <= 5'd1;
            state_q <= S_DAY;
          end
        end
        S_DAY: begin
          if (sub_ge) begin
            rem_q <= sub_r;
            day_q <= day_q + 5'd1;
            doy_q <= doy_q + 9'd1;
            wd_q <= wd_add(wd_q, 3'd1);
          end else begin
            tq_q <= '0;
            state_q <= S_HOUR;
          end
        end
        S_HOUR, S_MIN, S_SEC: begin
          if (sub_ge) begin
            rem_q <= sub_r;
            tq_q <= tq_q + 6'd1;
          end else begin
            tq_q <= '0;
            if (state_q == S_HOUR) begin
              hour_q <= tq_q[4:0];
              state_q <= S_MIN;
            end else if (state_q == S_MIN) begin
              min_q <= tq_q;
              state_q <= S_SEC;
            end else begin
              sec_q <= tq_q;
              ms_q <= rem_q[9:0];
              out_q <= 1'b1;
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ok = yr_q <= YW'(MAX_YEAR);
  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_q;
  assign valid_res_o = ok;
  assign year_o = ok ? yr_q[YearW-1:0] : '0;
  assign month_o = ok ? mon_q : '0;
  assign day_o = ok ? day_q : '0;
  assign day_of_year_o = ok ? doy_q : '0;
  assign weekday_o = ok ? wd_q : '0;
  assign hour_o = ok ? hour_q : '0;
  assign minute_o = ok ? min_q : '0;
  assign second_o = ok ? sec_q : '0;
  assign millisecond_o = ok ? ms_q : '0;
endmodule

// ----- hdl/tcf_checker.sv -----
// Port-level checker for the calendar conversion, bound to the top level.
// Depends on the assertion macros header.
`include "timestamp_to_calendar_fields_macros.svh"
module tcf_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic valid_res_o,
  input logic [3:0] month_o
);
  logic mon_ok;
  assign mon_ok = month_o != 4'd0 && month_o <= 4'd12;

  `TCF_ASSERT(a_busy, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after beat")
  `TCF_ASSERT(a_excl, clk_i, rst_ni, !(out_valid_o && in_ready_o), "ready while result held")
  `TCF_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `TCF_ASSERT(a_mon, clk_i, rst_ni, (out_valid_o && valid_res_o) |-> mon_ok, "bad month")
endmodule

bind timestamp_to_calendar_fields tcf_port_checker u_tcf_port_checker (.*);
